// ===== hw/rtl/rau_pkg.sv =====
// Package: shared constants and types for the rational arithmetic unit.
package rau_pkg;
  localparam int OperandWidthDefault = 32;
  localparam int ResNumW = 64;
  localparam int ResDenW = 63;
  localparam int KindW = 3;

  localparam logic [KindW-1:0] KIND_ADD = 3'd0;
  localparam logic [KindW-1:0] KIND_SUB = 3'd1;
  localparam logic [KindW-1:0] KIND_MUL = 3'd2;
  localparam logic [KindW-1:0] KIND_DIV = 3'd3;
  localparam logic [KindW-1:0] KIND_LESS = 3'd4;
  localparam logic [KindW-1:0] KIND_EQ = 3'd5;
  localparam logic [KindW-1:0] KIND_ABS = 3'd6;

  // multiplier operation handed from sequencer to the shared unit
  typedef struct packed {
    logic        start;
    logic [31:0] a_mag;
    logic [31:0] b_mag;
  } rau_mul_req_t;
endpackage

// ===== hw/rtl/rau_if.sv =====
// Interfaces: input and result channels.
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] left_num;
  logic [30:0] left_den;
  logic [31:0] right_num;
  logic [30:0] right_den;
  modport source (output valid, kind, left_num, left_den, right_num, right_den, input ready);
  modport sink (input valid, kind, left_num, left_den, right_num, right_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_num;
  logic [62:0] res_den;
  logic        compare_true;
  logic        status;
  modport source (output valid, res_num, res_den, compare_true, status, input ready);
  modport sink (input valid, res_num, res_den, compare_true, status, output ready);
endinterface

// ===== hw/rtl/rau_mul.sv =====
// Shift-add unsigned multiplier, one bit per cycle.
module rau_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  rau_pkg::rau_mul_req_t req,
  output logic                  done,
  output logic [63:0]           prod
);
  import rau_pkg::*;
  logic [31:0] mcand;
  logic [31:0] mplier;
  logic [5:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        mcand  <= req.a_mag;
        mplier <= req.b_mag;
        prod   <= '0;
        cnt    <= '0;
      end else if (busy) begin
        if (mplier[0]) prod <= prod + ({32'd0, mcand} << cnt);
        mplier <= mplier >> 1;
        cnt    <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/rau_gcd.sv =====
// Binary gcd plus restoring division of both values by the gcd.
module rau_gcd (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] a_in,
  input  logic [62:0] b_in,
  output logic        done,
  output logic [62:0] a_out,
  output logic [62:0] b_out
);
  import rau_pkg::*;
  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_TWO  = 3'd1;
  localparam logic [2:0] G_ODD  = 3'd2;
  localparam logic [2:0] G_DIV  = 3'd3;

  logic [2:0]  state;
  logic [62:0] u, v, a_keep, b_keep, g, quo, rem;
  logic [5:0]  sh;
  logic [6:0]  bit_cnt;
  logic        pass;
  logic [63:0] trial;

  assign trial = {rem, quo[62]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        G_IDLE: begin
          if (start) begin
            u <= a_in; v <= b_in; a_keep <= a_in; b_keep <= b_in;
            sh <= '0; state <= G_TWO;
          end
        end
        G_TWO: begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1; v <= v >> 1; sh <= sh + 6'd1;
          end else state <= G_ODD;
        end
        G_ODD: begin
          if (!u[0]) u <= u >> 1;
          else if (!v[0]) v <= v >> 1;
          else if (u == v) begin
            g <= u << sh; quo <= a_keep; rem <= '0;
            bit_cnt <= '0; pass <= 1'b0; state <= G_DIV;
          end else if (u > v) u <= (u - v) >> 1;
          else v <= (v - u) >> 1;
        end
        G_DIV: begin
          if (!trial[63]) begin
            rem <= trial[62:0]; quo <= {quo[61:0], 1'b1};
          end else begin
            rem <= {rem[61:0], quo[62]}; quo <= {quo[61:0], 1'b0};
          end
          bit_cnt <= bit_cnt + 7'd1;
          if (bit_cnt == 7'd62) begin
            bit_cnt <= '0;
            if (!pass) begin
              a_out <= !trial[63] ? {quo[61:0], 1'b1} : {quo[61:0], 1'b0};
              quo <= b_keep; rem <= '0; pass <= 1'b1;
            end else begin
              b_out <= !trial[63] ? {quo[61:0], 1'b1} : {quo[61:0], 1'b0};
              done <= 1'b1; state <= G_IDLE;
            end
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Top level: rational arithmetic unit, sequencer over shared multiplier and gcd unit.
// Sequence: equal and unused kind go straight to the result; divide by zero stops after one
//   multiply; less takes two multiplies; arithmetic kinds take up to three multiplies, a
//   binary gcd and two divides by the gcd.
// Throughput: one word at a time; in.ready is high only while idle with no result held.
// Reset: rst, synchronous, returns the sequencer to idle with no result pending.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
  input logic clk,
  input logic rst,
  rau_in_if.sink    in,
  rau_out_if.source out
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M1W  = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M2W  = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_M3W  = 4'd6;
  localparam logic [3:0] S_COMB = 4'd7;
  localparam logic [3:0] S_GCD  = 4'd8;
  localparam logic [3:0] S_GW   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]  state;
  logic [2:0]  kind;
  logic [31:0] lmag, rmag, ldv, rdv;
  logic        lneg, rneg, rzero;
  logic [63:0] p1, p2, p3;  // ln*rd; rn*ld (ln*rn for mul); ld*rd (ld*rn for div); magnitudes
  logic        gcd_start, gcd_done, mul_done;
  logic [62:0] g_a, g_b, ga_out, gb_out;
  logic        res_neg;
  logic [63:0] mag;
  logic [63:0] prod;
  rau_mul_req_t mreq;

  // sign extension and field cleanup of the incoming word
  logic [31:0] ln_s, rn_s, ld_s, rd_s;
  always_comb begin
    ln_s = 32'(signed'(in.left_num[OPERAND_WIDTH-1:0]));
    rn_s = 32'(signed'(in.right_num[OPERAND_WIDTH-1:0]));
    ld_s = 32'(in.left_den[OPERAND_WIDTH-2:0]);
    rd_s = 32'(in.right_den[OPERAND_WIDTH-2:0]);
    if (ld_s == '0) ld_s = 32'd1;
    if (rd_s == '0) rd_s = 32'd1;
  end

  rau_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mul_done), .prod(prod));
  rau_gcd u_gcd (.clk(clk), .rst(rst), .start(gcd_start), .a_in(g_a), .b_in(g_b),
                 .done(gcd_done), .a_out(ga_out), .b_out(gb_out));

  always_comb begin
    mreq = '0;
    case (state)
      S_M1: begin mreq.start = 1'b1; mreq.a_mag = lmag; mreq.b_mag = rdv; end
      S_M2: begin
        mreq.start = 1'b1;
        mreq.a_mag = (kind == KIND_MUL) ? lmag : rmag;
        mreq.b_mag = (kind == KIND_MUL) ? rmag : ldv;
      end
      S_M3: begin
        mreq.start = 1'b1; mreq.a_mag = ldv;
        mreq.b_mag = (kind == KIND_DIV) ? rmag : rdv;
      end
      default: mreq = '0;
    endcase
  end

  assign in.ready = (state == S_IDLE) && !out.valid;
  // mag is settled by the time the gcd is launched; a zero result skips the gcd
  assign g_a = mag[62:0];
  assign gcd_start = (state == S_GCD) && (mag != '0);

  // signed combine of cross products; less uses the difference
  logic signed [65:0] t1, t2, sum;
  always_comb begin
    t1 = lneg ? -$signed({2'b0, p1}) : $signed({2'b0, p1});
    t2 = rneg ? -$signed({2'b0, p2}) : $signed({2'b0, p2});
    sum = (kind == KIND_ADD) ? t1 + t2 : t1 - t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out.valid <= 1'b0;
    end else begin
      if (out.valid && out.ready) out.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            kind  <= in.kind;
            lneg  <= ln_s[31]; rneg <= rn_s[31];
            lmag  <= ln_s[31] ? -ln_s : ln_s;
            rmag  <= rn_s[31] ? -rn_s : rn_s;
            rzero <= rn_s == '0;
            ldv   <= ld_s; rdv <= rd_s;
            out.res_num <= 64'd0; out.res_den <= 63'd1;
            out.compare_true <= 1'b0; out.status <= 1'b0;
            case (in.kind)
              KIND_ADD, KIND_SUB, KIND_LESS, KIND_DIV: state <= S_M1;
              KIND_MUL: state <= S_M2;
              KIND_EQ: begin
                out.compare_true <= (ln_s == rn_s) && (ld_s == rd_s);
                state <= S_OUT;
              end
              KIND_ABS: state <= S_COMB;
              default: state <= S_OUT;
            endcase
          end
        end
        S_M1: state <= S_M1W;
        S_M1W: if (mul_done) begin
          p1 <= prod;
          if (kind == KIND_DIV) begin
            if (rzero) begin out.status <= 1'b1; state <= S_OUT; end
            else state <= S_M3;
          end else state <= S_M2;
        end
        S_M2: state <= S_M2W;
        S_M2W: if (mul_done) begin
          p2 <= prod;
          state <= (kind == KIND_LESS) ? S_COMB : S_M3;
        end
        S_M3: state <= S_M3W;
        S_M3W: if (mul_done) begin p3 <= prod; state <= S_COMB; end
        S_COMB: begin
          state <= S_GCD;
          case (kind)
            KIND_ADD, KIND_SUB: begin
              res_neg <= sum[65]; mag <= sum[65] ? 64'(-sum) : 64'(sum);
              g_b <= p3[62:0];
            end
            KIND_MUL: begin
              res_neg <= lneg ^ rneg; mag <= p2; g_b <= p3[62:0];
            end
            KIND_DIV: begin
              res_neg <= lneg ^ rneg; mag <= p1; g_b <= p3[62:0];
            end
            KIND_LESS: begin
              out.compare_true <= sum[65];
              state <= S_OUT;
            end
            default: begin  // absolute value
              res_neg <= 1'b0; mag <= {32'd0, lmag}; g_b <= {31'd0, ldv};
            end
          endcase
        end
        S_GCD: begin
          if (mag == '0) state <= S_OUT;
          else state <= S_GW;
        end
        S_GW: if (gcd_done) begin
          out.res_num <= res_neg ? -{1'b0, ga_out} : {1'b0, ga_out};
          out.res_den <= gb_out;
          state <= S_OUT;
        end
        S_OUT: begin
          out.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/tb.sv =====
// Testbench for the rational arithmetic unit: directed table, random words, predictor check.
`timescale 1ns / 100ps

module tb;
  import rau_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int RandomWords = 900;
  localparam int DrainCycles = 300;
  localparam int LongHold = 3000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] lnum;
    logic [30:0] lden;
    logic [31:0] rnum;
    logic [30:0] rden;
  } operands_t;

  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic        cmp;
    logic        st;
  } fraction_res_t;

  // directed row: operands plus an optional hand-typed answer
  typedef struct {
    operands_t     op;
    bit            typed;
    fraction_res_t res;
  } vector_row_t;

  logic clk;
  logic rst;

  rau_in_if  in_w ();
  rau_out_if out_w ();

  rational_arithmetic_unit dut (
    .clk(clk),
    .rst(rst),
    .in(in_w),
    .out(out_w)
  );

  fraction_res_t pending_q[$];
  int            n_errors;
  int            n_sent;
  int            n_checked;
  int            n_cycles;
  int            n_divzero;
  int            n_compare;
  logic          hold_rx;
  logic          quiet_window;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Euclid on magnitudes; den is never zero here
  function automatic fraction_res_t reduce_frac(longint n, longint unsigned d);
    fraction_res_t   r;
    longint unsigned mag;
    longint unsigned a;
    longint unsigned b;
    longint unsigned t;
    r = '{num: 64'd0, den: 63'd1, cmp: 1'b0, st: 1'b0};
    if (n == 0 || d == 0) return r;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    a = mag;
    b = d;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    mag = mag / a;
    d = d / a;
    r.num = (n < 0) ? (64'd0 - mag) : mag;
    r.den = d[62:0];
    return r;
  endfunction

  // expected result word for one operand word
  function automatic fraction_res_t rational_result(operands_t op);
    fraction_res_t r;
    longint        ln;
    longint        ld;
    longint        rn;
    longint        rd;
    longint        num;
    longint        rmag;
    ln = longint'(signed'(op.lnum));
    rn = longint'(signed'(op.rnum));
    ld = (op.lden == 0) ? 1 : longint'({33'd0, op.lden});
    rd = (op.rden == 0) ? 1 : longint'({33'd0, op.rden});
    r = '{num: 64'd0, den: 63'd1, cmp: 1'b0, st: 1'b0};
    case (op.kind)
      KIND_ADD: r = reduce_frac(ln * rd + rn * ld, ld * rd);
      KIND_SUB: r = reduce_frac(ln * rd - rn * ld, ld * rd);
      KIND_MUL: r = reduce_frac(ln * rn, ld * rd);
      KIND_DIV: begin
        if (rn == 0) begin
          r.st = 1'b1;
        end else begin
          num = ln * rd;
          rmag = (rn < 0) ? -rn : rn;
          if (rn < 0) num = -num;
          r = reduce_frac(num, ld * rmag);
        end
      end
      KIND_LESS: r.cmp = (ln * rd < rn * ld);
      KIND_EQ:   r.cmp = (ln == rn && ld == rd);
      KIND_ABS:  r = reduce_frac((ln < 0) ? -ln : ln, ld);
      default: ;
    endcase
    return r;
  endfunction

  // numerator: mix of extremes, small values and full-range noise
  function automatic logic [31:0] pick_num();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h8000_0000;
    if (r < 16) return 32'h7fff_ffff;
    if (r < 24) return 32'd0;
    if (r < 60) return 32'($signed($urandom_range(0, 200)) - 100);
    return $urandom;
  endfunction

  function automatic logic [30:0] pick_den();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 31'd0;
    if (r < 10) return 31'h7fff_ffff;
    if (r < 55) return 31'($urandom_range(1, 60));
    return 31'($urandom);
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // offer one word, hold it until taken, then log its expected result
  task automatic send_word(operands_t op, bit typed, fraction_res_t res);
    int gap;
    gap = quiet_window ? 0 : pick_gap();
    if (gap > 0) begin
      in_w.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_w.kind = op.kind;
    in_w.left_num = op.lnum;
    in_w.left_den = op.lden;
    in_w.right_num = op.rnum;
    in_w.right_den = op.rden;
    in_w.valid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_w.ready) break;
    end
    pending_q.push_back(typed ? res : rational_result(op));
    n_sent++;
    if (op.kind == KIND_DIV && op.rnum == 0) n_divzero++;
    if (op.kind == KIND_LESS || op.kind == KIND_EQ) n_compare++;
    @(negedge clk);
  endtask

  // result checker: compare each taken word with the oldest expectation
  always @(posedge clk) begin
    fraction_res_t want;
    if (!rst && out_w.valid && out_w.ready) begin
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected: num %0d den %0d",
               $signed(out_w.res_num), out_w.res_den);
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_w.res_num !== want.num) begin
          $error("res_num: expected %0d got %0d", $signed(want.num), $signed(out_w.res_num));
          n_errors++;
        end
        if (out_w.res_den !== want.den) begin
          $error("res_den: expected %0d got %0d", want.den, out_w.res_den);
          n_errors++;
        end
        if (out_w.compare_true !== want.cmp) begin
          $error("compare_true: expected %0b got %0b", want.cmp, out_w.compare_true);
          n_errors++;
        end
        if (out_w.status !== want.st) begin
          $error("status: expected %0b got %0b", want.st, out_w.status);
          n_errors++;
        end
      end
      n_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", n_cycles, pending_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // long receiver hold-off once the run is under way; the sender keeps offering
  initial begin
    hold_rx = 1'b0;
    wait (n_checked >= 150);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (LongHold) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // receiver: random stalls, short mostly, some long, none in the quiet window
  initial begin
    int stall;
    out_w.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_w.ready = 1'b0;
      end else if (quiet_window) begin
        out_w.ready = 1'b1;
      end else if (stall > 0) begin
        out_w.ready = 1'b0;
        stall--;
      end else begin
        out_w.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    vector_row_t   rows[$];
    operands_t     op;
    fraction_res_t z;
    int            wait_cnt;

    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_cycles = 0;
    n_divzero = 0;
    n_compare = 0;
    quiet_window = 1'b0;
    rst = 1'b1;
    in_w.valid = 1'b0;
    in_w.kind = KIND_ADD;
    in_w.left_num = '0;
    in_w.left_den = 31'd1;
    in_w.right_num = '0;
    in_w.right_den = 31'd1;

    z = '{num: 64'd0, den: 63'd1, cmp: 1'b0, st: 1'b0};
    // kind, left num/den, right num/den; typed answer where obvious
    rows = '{
      '{'{KIND_ADD, 32'd1, 31'd2, 32'd1, 31'd3}, 1'b0, z},
      '{'{KIND_ADD, 32'd0, 31'd1, 32'd0, 31'd1}, 1'b1, z},
      '{'{KIND_SUB, 32'd1, 31'd2, 32'd1, 31'd2}, 1'b1, z},
      '{'{KIND_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1}, 1'b0, z},
      '{'{KIND_SUB, 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'd1}, 1'b0, z},
      '{'{KIND_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1}, 1'b1,
        '{64'h4000_0000_0000_0000, 63'd1, 1'b0, 1'b0}},
      '{'{KIND_MUL, 32'd1, 31'h7fff_ffff, 32'd1, 31'h7fff_ffff}, 1'b0, z},
      '{'{KIND_MUL, 32'd3, 31'd7, 32'hffff_fffe, 31'd9}, 1'b0, z},
      // divide by a zero fraction: status set, result forced to 0/1
      '{'{KIND_DIV, 32'd5, 31'd3, 32'd0, 31'd7}, 1'b1, '{64'd0, 63'd1, 1'b0, 1'b1}},
      '{'{KIND_DIV, 32'hffff_fffd, 31'd4, 32'hffff_fffa, 31'd5}, 1'b0, z},
      '{'{KIND_DIV, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'd1}, 1'b0, z},
      '{'{KIND_LESS, 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'd1}, 1'b1,
        '{64'd0, 63'd1, 1'b1, 1'b0}},
      '{'{KIND_LESS, 32'd1, 31'd2, 32'd2, 31'd4}, 1'b1, z},
      '{'{KIND_LESS, 32'h7fff_ffff, 31'd1, 32'h8000_0000, 31'd1}, 1'b1, z},
      // equality is field-wise, so 2/4 differs from 1/2
      '{'{KIND_EQ, 32'd2, 31'd4, 32'd1, 31'd2}, 1'b1, z},
      '{'{KIND_EQ, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff}, 1'b1,
        '{64'd0, 63'd1, 1'b1, 1'b0}},
      '{'{KIND_ABS, 32'h8000_0000, 31'd1, 32'd0, 31'd1}, 1'b1,
        '{64'h0000_0000_8000_0000, 63'd1, 1'b0, 1'b0}},
      '{'{KIND_ABS, 32'd6, 31'd4, 32'd9, 31'd9}, 1'b1, '{64'd3, 63'd2, 1'b0, 1'b0}},
      // zero denominators read as one
      '{'{KIND_ADD, 32'd1, 31'd0, 32'd1, 31'd0}, 1'b1, '{64'd2, 63'd1, 1'b0, 1'b0}},
      '{'{KIND_EQ, 32'd5, 31'd0, 32'd5, 31'd1}, 1'b1, '{64'd0, 63'd1, 1'b1, 1'b0}},
      // unused kind
      '{'{3'd7, 32'd9, 31'd2, 32'd4, 31'd3}, 1'b1, z},
      '{'{KIND_SUB, 32'd6, 31'd8, 32'hffff_fffe, 31'd8}, 1'b0, z}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_word(rows[i].op, rows[i].typed, rows[i].res);

    for (int i = 0; i < RandomWords; i++) begin
      quiet_window = (i >= 500 && i < 580);
      op.kind = ($urandom_range(0, 49) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      op.lnum = pick_num();
      op.lden = pick_den();
      op.rnum = pick_num();
      op.rden = pick_den();
      // equal operands now and then so equality can come out true
      if (op.kind == KIND_EQ && $urandom_range(0, 1)) begin
        op.rnum = op.lnum;
        op.rden = op.lden;
      end
      send_word(op, 1'b0, z);
    end
    quiet_window = 1'b0;
    in_w.valid = 1'b0;

    wait_cnt = 0;
    while (pending_q.size() != 0 && wait_cnt < 100_000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (pending_q.size() != 0) begin
      $error("%0d result words never arrived", pending_q.size());
      n_errors++;
    end
    repeat (DrainCycles) @(posedge clk);

    $display("%0d words sent, %0d results checked over %0d cycles", n_sent, n_checked, n_cycles);
    $display("%0d compares, %0d zero divides, one long output hold-off", n_compare, n_divzero);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
